### hdl/midi_track_note_extractor_assert.svh
// Assertion macros shared by the checker files.
`ifndef MIDI_TRACK_NOTE_EXTRACTOR_ASSERT_SVH
`define MIDI_TRACK_NOTE_EXTRACTOR_ASSERT_SVH

// same-cycle implication
`define MTNE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MTNE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/mtne_pkg.sv
// ---------------------------------------------------------------------------
// mtne_pkg
// Types and constants of the MIDI track note extractor.
// ---------------------------------------------------------------------------
package mtne_pkg;

   localparam int PENDING_SLOTS_DEF = 16;

   localparam logic [7:0] ST_SYSEX   = 8'hF0;
   localparam logic [7:0] ST_ESCAPE  = 8'hF7;
   localparam logic [7:0] ST_META    = 8'hFF;
   localparam logic [7:0] META_EOT   = 8'h2F;
   localparam logic [3:0] KIND_OFF   = 4'h8;
   localparam logic [3:0] KIND_ON    = 4'h9;
   localparam logic [3:0] KIND_PROG  = 4'hC;
   localparam logic [3:0] KIND_PRESS = 4'hD;
   localparam logic [3:0] KIND_SYS   = 4'hF;
   localparam logic [6:0] PITCH_MAX  = 7'h7F;

   typedef enum logic [3:0] {
      PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE,
      PH_META_LEN, PH_SYSEX_LEN, PH_SKIP, PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      C_IDLE, C_HOLD, C_SCAN, C_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic [31:0] start;
      logic [6:0]  pitch;
      logic [7:0]  vel;
   } pend_type;

   typedef struct packed {
      logic byte_step;
      logic flush_start;
      logic emit;
      logic next_pitch;
      logic track_clear;
   } cmd_type;

   typedef struct packed {
      logic byte_hit;
      logic match_any;
      logic last_pitch;
   } stat_type;

endpackage

### hdl/mtne_ctrl.sv
// ---------------------------------------------------------------------------
// mtne_ctrl
// Sequencer: byte handling, result hand-off and the flush pitch walk.
// ---------------------------------------------------------------------------
module mtne_ctrl
   import mtne_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   input  logic     req_mode,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (req_tvalid) begin
               if (req_mode) state_in = C_SCAN;
               else if (stat.byte_hit) state_in = C_HOLD;
            end
         end
         C_HOLD: begin
            if (rsp_tready) state_in = C_IDLE;
         end
         C_SCAN: begin
            if (stat.match_any) state_in = C_EMIT;
            else if (stat.last_pitch) state_in = C_IDLE;
         end
         C_EMIT: begin
            if (rsp_tready) state_in = C_SCAN;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         C_IDLE: begin
            req_tready      = 1'b1;
            cmd.byte_step   = req_tvalid & ~req_mode;
            cmd.flush_start = req_tvalid & req_mode;
         end
         C_HOLD: rsp_tvalid = 1'b1;
         C_SCAN: begin
            cmd.emit        = stat.match_any;
            cmd.next_pitch  = ~stat.match_any;
            cmd.track_clear = ~stat.match_any & stat.last_pitch;
         end
         C_EMIT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

endmodule

### hdl/mtne_dpath.sv
// ---------------------------------------------------------------------------
// mtne_dpath
// Track parser state, pending-note pool and the result register.
// ---------------------------------------------------------------------------
module mtne_dpath
   import mtne_pkg::*;
#(
   parameter int PENDING_SLOTS = PENDING_SLOTS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  listen_channel,
   input  logic [7:0]  data_byte,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic [31:0] start_tick,
   output logic [31:0] end_tick,
   output logic [6:0]  pitch,
   output logic [7:0]  velocity,
   output logic        hanging,
   output logic [7:0]  dropped_ons,
   output logic        last
);

   localparam int IW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
   localparam int UW = $clog2(PENDING_SLOTS + 1);
   localparam logic [UW-1:0] SLOTS_U = UW'(PENDING_SLOTS);

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] tick_ff, tick_in;
   logic [7:0]  rs_ff, rs_in;
   logic        rv_ff, rv_in;
   logic [31:0] skip_ff, skip_in;
   logic [7:0]  meta_ff, meta_in;
   logic [7:0]  first_ff, first_in;
   logic [UW-1:0] used_ff, used_in;
   logic [7:0]  drop_ff, drop_in;
   pend_type    pool_ff [PENDING_SLOTS];
   pend_type    pool_in [PENDING_SLOTS];
   logic [6:0]  scan_ff, scan_in;
   logic [PENDING_SLOTS-1:0] done_ff, done_in;
   logic [UW-1:0] cnt_ff, cnt_in;

   // output word register
   logic [31:0] o_start_ff, o_end_ff;
   logic [6:0]  o_pitch_ff;
   logic [7:0]  o_vel_ff, o_drop_ff;
   logic        o_hang_ff, o_last_ff;

   // byte decode
   logic [7:0]  st;
   logic        do_close, do_open;
   logic [PENDING_SLOTS-1:0] valid_v, close_v, scan_v;
   logic        close_found, scan_found;
   logic [IW-1:0] close_idx, scan_idx;
   logic [31:0] acc_sh, skip_sh;

   always_comb begin
      for (int j = 0; j < PENDING_SLOTS; j++) begin
         valid_v[j] = UW'(j) < used_ff;
         close_v[j] = valid_v[j] && !first_ff[7] && pool_ff[j].pitch == first_ff[6:0];
         scan_v[j]  = valid_v[j] && !done_ff[j] && pool_ff[j].pitch == scan_ff;
      end
      close_found = 1'b0;
      close_idx   = '0;
      scan_found  = 1'b0;
      scan_idx    = '0;
      for (int j = PENDING_SLOTS - 1; j >= 0; j--) begin
         if (close_v[j]) begin
            close_found = 1'b1;
            close_idx   = IW'(j);
         end
         if (scan_v[j]) begin
            scan_found = 1'b1;
            scan_idx   = IW'(j);
         end
      end
   end

   assign acc_sh  = {acc_ff[24:0], data_byte[6:0]};
   assign skip_sh = {skip_ff[24:0], data_byte[6:0]};

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      tick_in  = tick_ff;
      rs_in    = rs_ff;
      rv_in    = rv_ff;
      skip_in  = skip_ff;
      meta_in  = meta_ff;
      first_in = first_ff;
      do_close = 1'b0;
      do_open  = 1'b0;
      st       = data_byte[7] ? data_byte : rs_ff;
      unique case (phase_ff)
         PH_DELTA: begin
            acc_in = acc_sh;
            if (!data_byte[7]) begin
               tick_in  = tick_ff + acc_sh;
               acc_in   = '0;
               phase_in = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (!data_byte[7] && !rv_ff) begin
               phase_in = PH_HALT;
            end else begin
               if (st != ST_SYSEX && st != ST_ESCAPE && st != ST_META) begin
                  rs_in = st;
                  rv_in = 1'b1;
               end
               if (st == ST_META) begin
                  phase_in = PH_META_TYPE;
               end else if (st == ST_SYSEX || st == ST_ESCAPE) begin
                  skip_in  = '0;
                  phase_in = PH_SYSEX_LEN;
               end else if (st[7:4] == KIND_SYS) begin
                  phase_in = PH_HALT;
               end else if (!data_byte[7]) begin
                  // running status: this byte is already the first data byte
                  first_in = data_byte;
                  phase_in = (st[7:4] == KIND_PROG || st[7:4] == KIND_PRESS) ?
                             PH_DELTA : PH_DATA2;
               end else begin
                  phase_in = PH_DATA1;
               end
            end
         end
         PH_DATA1: begin
            first_in = data_byte;
            phase_in = (rs_ff[7:4] == KIND_PROG || rs_ff[7:4] == KIND_PRESS) ?
                       PH_DELTA : PH_DATA2;
         end
         PH_DATA2: begin
            phase_in = PH_DELTA;
            if (rs_ff[3:0] == listen_channel) begin
               if (rs_ff[7:4] == KIND_ON) begin
                  if (data_byte == 8'd0) do_close = 1'b1;
                  else do_open = !first_ff[7];
               end else if (rs_ff[7:4] == KIND_OFF) begin
                  do_close = 1'b1;
               end
            end
         end
         PH_META_TYPE: begin
            meta_in  = data_byte;
            skip_in  = '0;
            phase_in = PH_META_LEN;
         end
         PH_META_LEN, PH_SYSEX_LEN: begin
            skip_in = skip_sh;
            if (!data_byte[7]) begin
               if (phase_ff == PH_META_LEN && meta_ff == META_EOT) phase_in = PH_HALT;
               else if (skip_sh == '0) phase_in = PH_DELTA;
               else phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (skip_ff != '0) skip_in = skip_ff - 32'd1;
            if (skip_ff <= 32'd1) phase_in = PH_DELTA;
         end
         default: phase_in = PH_HALT;
      endcase
   end

   assign stat.byte_hit   = (phase_ff == PH_DATA2) && (rs_ff[3:0] == listen_channel) &&
                            ((rs_ff[7:4] == KIND_ON && data_byte == 8'd0) ||
                             rs_ff[7:4] == KIND_OFF) && close_found;
   assign stat.match_any  = scan_found;
   assign stat.last_pitch = (scan_ff == PITCH_MAX);

   // pool update: close shifts later entries down, open appends
   always_comb begin
      for (int j = 0; j < PENDING_SLOTS; j++) pool_in[j] = pool_ff[j];
      used_in = used_ff;
      drop_in = drop_ff;
      if (cmd.byte_step && do_close && close_found) begin
         for (int j = 0; j < PENDING_SLOTS - 1; j++) begin
            if (IW'(j) >= close_idx) pool_in[j] = pool_ff[j + 1];
         end
         used_in = used_ff - UW'(1);
      end
      if (cmd.byte_step && do_open) begin
         if (used_ff < SLOTS_U) begin
            pool_in[used_ff[IW-1:0]] = '{start: tick_ff, pitch: first_ff[6:0],
                                         vel: data_byte};
            used_in = used_ff + UW'(1);
         end else if (drop_ff != 8'hFF) begin
            drop_in = drop_ff + 8'd1;
         end
      end
   end

   always_comb begin
      scan_in = scan_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      if (cmd.flush_start) begin
         scan_in = '0;
         done_in = '0;
         cnt_in  = '0;
      end else if (cmd.emit) begin
         done_in[scan_idx] = 1'b1;
         cnt_in = cnt_ff + UW'(1);
      end else if (cmd.next_pitch) begin
         scan_in = scan_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.track_clear) begin
         phase_ff <= PH_DELTA;
         acc_ff   <= '0;
         tick_ff  <= '0;
         rs_ff    <= '0;
         rv_ff    <= 1'b0;
         skip_ff  <= '0;
         meta_ff  <= '0;
         used_ff  <= '0;
         drop_ff  <= '0;
      end else if (cmd.flush_start) begin
         tick_ff <= tick_ff + acc_ff;
         acc_ff  <= '0;
      end else if (cmd.byte_step) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         tick_ff  <= tick_in;
         rs_ff    <= rs_in;
         rv_ff    <= rv_in;
         skip_ff  <= skip_in;
         meta_ff  <= meta_in;
         used_ff  <= used_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.byte_step) begin
         first_ff <= first_in;
         for (int j = 0; j < PENDING_SLOTS; j++) pool_ff[j] <= pool_in[j];
      end
      scan_ff <= scan_in;
      done_ff <= done_in;
      cnt_ff  <= cnt_in;
      if (cmd.byte_step && stat.byte_hit) begin
         o_start_ff <= pool_ff[close_idx].start;
         o_pitch_ff <= pool_ff[close_idx].pitch;
         o_vel_ff   <= pool_ff[close_idx].vel;
         o_end_ff   <= tick_ff;
         o_hang_ff  <= 1'b0;
         o_drop_ff  <= drop_ff;
         o_last_ff  <= 1'b1;
      end else if (cmd.emit) begin
         o_start_ff <= pool_ff[scan_idx].start;
         o_pitch_ff <= pool_ff[scan_idx].pitch;
         o_vel_ff   <= pool_ff[scan_idx].vel;
         o_end_ff   <= tick_ff;
         o_hang_ff  <= 1'b1;
         o_drop_ff  <= drop_ff;
         o_last_ff  <= (cnt_ff + UW'(1)) == used_ff;
      end
   end

   assign start_tick  = o_start_ff;
   assign end_tick    = o_end_ff;
   assign pitch       = o_pitch_ff;
   assign velocity    = o_vel_ff;
   assign hanging     = o_hang_ff;
   assign dropped_ons = o_drop_ff;
   assign last        = o_last_ff;

endmodule

### hdl/midi_track_note_extractor.sv
// A track byte that closes a pending note stalls the input until its word is taken. A
// flush walks all 128 pitches against the pending pool; for each pending note of the
// pitch under scan it emits a word and waits for it to be taken before scanning on.
// Results are one word at a time.
// ---------------------------------------------------------------------------
// midi_track_note_extractor
// Parses a MIDI track body and emits closed notes, and hanging notes on flush.
// ---------------------------------------------------------------------------
module midi_track_note_extractor
   import mtne_pkg::*;
#(
   parameter int PENDING_SLOTS = PENDING_SLOTS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,   // listen_channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // data_byte
   input  logic        req_tuser,     // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // start_tick[31:0], end_tick[63:32], pitch[70:64], velocity[78:71],
   // dropped_ons[86:79], zero[87]
   output logic [87:0] rsp_tdata,
   output logic        rsp_tuser,     // hanging
   output logic        rsp_tlast      // last
);

   logic [3:0]  chan_ff;
   cmd_type     cmd;
   stat_type    stat;
   logic [31:0] start_tick, end_tick;
   logic [6:0]  pitch;
   logic [7:0]  velocity, dropped_ons;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
      end else if (csr_wr_en) begin
         chan_ff <= csr_wr_data;
      end
   end

   mtne_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mtne_dpath #(.PENDING_SLOTS(PENDING_SLOTS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .listen_channel (chan_ff),
      .data_byte      (req_tdata),
      .cmd            (cmd),
      .stat           (stat),
      .start_tick     (start_tick),
      .end_tick       (end_tick),
      .pitch          (pitch),
      .velocity       (velocity),
      .hanging        (rsp_tuser),
      .dropped_ons    (dropped_ons),
      .last           (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, dropped_ons, velocity, pitch, end_tick, start_tick};

endmodule

### hdl/mtne_checker.sv
// ---------------------------------------------------------------------------
// mtne_checker
// Port-level checks of the note extractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "midi_track_note_extractor_assert.svh"

module mtne_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // stalled word holds
   `MTNE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // one item in flight: no byte taken while a word waits
   `MTNE_ASSERT_IMP(a_one_item, clock, reset, rsp_tvalid, !req_tready)
   // a closed note always carries a nonzero velocity
   `MTNE_ASSERT_IMP(a_vel_nz, clock, reset, rsp_tvalid, rsp_tdata[78:71] != 8'd0)
   // a regular close is the only word of its byte
   `MTNE_ASSERT_IMP(a_close_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)

endmodule

bind midi_track_note_extractor mtne_checker u_mtne_checker (.*);

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives MIDI track bytes and flushes into the note extractor and checks every
// emitted note word against a cycle-free predictor of the track parser.
// ---------------------------------------------------------------------------

class note_scoreboard;
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] stop;
      logic [6:0]  pitch;
      logic [7:0]  vel;
      logic        hang;
      logic [7:0]  drops;
      logic        last;
   } note_word;

   typedef struct {
      logic [31:0] start;
      logic [7:0]  pitch;
      logic [7:0]  vel;
   } open_note;

   note_word    expected_notes[$];
   open_note    pool[$];
   logic [3:0]  channel;
   mtne_pkg::phase_type phase;
   logic [31:0] delta, ticks, skip_left;
   logic [7:0]  run_status, meta_kind, data1, drops;
   bit          run_valid;
   int          errors;

   function void clear_track();
      phase = mtne_pkg::PH_DELTA;
      delta = 0; ticks = 0; skip_left = 0;
      run_status = 0; meta_kind = 0; data1 = 0; drops = 0;
      run_valid = 0;
      pool.delete();
   endfunction

   function void set_channel(logic [3:0] ch);
      channel = ch;
   endfunction

   function void emit(open_note n, logic [31:0] stop, bit hang, bit last);
      note_word w;
      w.start = n.start; w.stop = stop; w.pitch = n.pitch[6:0]; w.vel = n.vel;
      w.hang = hang; w.drops = drops; w.last = last;
      expected_notes = {expected_notes, w};
   endfunction

   function void close_pitch(logic [7:0] p);
      if (p[7]) return;
      foreach (pool[i])
         if (pool[i].pitch == p) begin
            emit(pool[i], ticks, 0, 1);
            pool.delete(i);
            return;
         end
   endfunction

   function void take_first(logic [7:0] b);
      data1 = b;
      phase = (run_status[7:4] == mtne_pkg::KIND_PROG || run_status[7:4] == mtne_pkg::KIND_PRESS)
         ? mtne_pkg::PH_DELTA : mtne_pkg::PH_DATA2;
   endfunction

   function void note_input(bit flush, logic [7:0] b);
      logic [7:0] st;
      open_note n;
      int k;
      if (flush) begin
         ticks += delta;
         k = 0;
         for (int p = 0; p < 128; p++)
            foreach (pool[i])
               if (pool[i].pitch == p) begin
                  k++;
                  emit(pool[i], ticks, 1, k == pool.size());
               end
         clear_track();
         return;
      end
      case (phase)
         mtne_pkg::PH_DELTA: begin
            delta = {delta[24:0], b[6:0]};
            if (!b[7]) begin
               ticks += delta; delta = 0; phase = mtne_pkg::PH_STATUS;
            end
         end
         mtne_pkg::PH_STATUS: begin
            if (!b[7] && !run_valid) phase = mtne_pkg::PH_HALT;
            else begin
               st = b[7] ? b : run_status;
               if (st != mtne_pkg::ST_SYSEX && st != mtne_pkg::ST_ESCAPE
                   && st != mtne_pkg::ST_META) begin
                  run_status = st; run_valid = 1;
               end
               if (st == mtne_pkg::ST_META) phase = mtne_pkg::PH_META_TYPE;
               else if (st == mtne_pkg::ST_SYSEX || st == mtne_pkg::ST_ESCAPE) begin
                  skip_left = 0; phase = mtne_pkg::PH_SYSEX_LEN;
               end else if (st[7:4] == mtne_pkg::KIND_SYS) phase = mtne_pkg::PH_HALT;
               else if (!b[7]) take_first(b);
               else phase = mtne_pkg::PH_DATA1;
            end
         end
         mtne_pkg::PH_DATA1: take_first(b);
         mtne_pkg::PH_DATA2: begin
            phase = mtne_pkg::PH_DELTA;
            if (run_status[3:0] == channel) begin
               if (run_status[7:4] == mtne_pkg::KIND_ON && b != 0) begin
                  if (!data1[7]) begin
                     if (pool.size() >= mtne_pkg::PENDING_SLOTS_DEF) begin
                        if (drops != 8'hFF) drops++;
                     end else begin
                        n.start = ticks; n.pitch = data1; n.vel = b;
                        pool = {pool, n};
                     end
                  end
               end else if (run_status[7:4] == mtne_pkg::KIND_ON
                            || run_status[7:4] == mtne_pkg::KIND_OFF)
                  close_pitch(data1);
            end
         end
         mtne_pkg::PH_META_TYPE: begin
            meta_kind = b; skip_left = 0; phase = mtne_pkg::PH_META_LEN;
         end
         mtne_pkg::PH_META_LEN, mtne_pkg::PH_SYSEX_LEN: begin
            skip_left = {skip_left[24:0], b[6:0]};
            if (!b[7]) begin
               if (phase == mtne_pkg::PH_META_LEN && meta_kind == mtne_pkg::META_EOT)
                  phase = mtne_pkg::PH_HALT;
               else if (skip_left == 0) phase = mtne_pkg::PH_DELTA;
               else phase = mtne_pkg::PH_SKIP;
            end
         end
         mtne_pkg::PH_SKIP: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) phase = mtne_pkg::PH_DELTA;
         end
         default: phase = mtne_pkg::PH_HALT;
      endcase
   endfunction

   function void check_word(logic [87:0] d, logic hang, logic last);
      note_word w;
      if (expected_notes.size() == 0) begin
         $error("unexpected result word %h", d);
         errors++;
         return;
      end
      w = expected_notes.pop_front();
      if (d[31:0] !== w.start) begin
         $error("start_tick exp %0d got %0d", w.start, d[31:0]); errors++;
      end
      if (d[63:32] !== w.stop) begin
         $error("end_tick exp %0d got %0d", w.stop, d[63:32]); errors++;
      end
      if (d[70:64] !== w.pitch) begin
         $error("pitch exp %0d got %0d", w.pitch, d[70:64]); errors++;
      end
      if (d[78:71] !== w.vel) begin
         $error("velocity exp %0d got %0d", w.vel, d[78:71]); errors++;
      end
      if (d[86:79] !== w.drops) begin
         $error("dropped_ons exp %0d got %0d", w.drops, d[86:79]); errors++;
      end
      if (hang !== w.hang) begin
         $error("hanging exp %0d got %0d", w.hang, hang); errors++;
      end
      if (last !== w.last) begin
         $error("last exp %0d got %0d", w.last, last); errors++;
      end
   endfunction
endclass

module testbench;
   import mtne_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [3:0]  csr_wr_data = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   note_scoreboard notes;
   int  idle_cycles;
   bit  long_hold = 0;
   bit  stim_done = 0;
   logic [3:0] chan;

   always #1 clock = ~clock;

   midi_track_note_extractor uut (.*);

   // one word per call; gap of random length first
   task automatic send_word(bit flush, logic [7:0] b);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
            ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1; req_tuser <= flush; req_tdata <= flush ? 8'($urandom) : b;
      do @(posedge clock); while (!req_tready);
      notes.note_input(flush, req_tuser ? 8'h00 : req_tdata);
      @(negedge clock);
   endtask

   task automatic send_note(logic [7:0] st, logic [7:0] p, logic [7:0] v);
      send_word(0, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127)) : 8'h00);
      send_word(0, st); send_word(0, p); send_word(0, v);
   endtask

   task automatic set_channel(logic [3:0] ch);
      req_tvalid <= 0;
      while (notes.expected_notes.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_wr_en <= 1; csr_wr_data <= ch;
      @(negedge clock);
      csr_wr_en <= 0;
      notes.set_channel(ch);
   endtask

   // one random event, mostly well formed
   task automatic random_event();
      int kind;
      logic [7:0] p;
      kind = $urandom_range(0, 99);
      p = 8'($urandom_range(60, 67));
      if (kind < 40)
         send_note({KIND_ON, ($urandom_range(0, 4) == 0) ? 4'($urandom) : chan}, p,
                   8'($urandom_range(1, 255)));
      else if (kind < 65)
         send_note({($urandom_range(0, 1) ? KIND_OFF : KIND_ON), chan}, p,
                   ($urandom_range(0, 1) ? 8'h00 : 8'($urandom)));
      else if (kind < 75) begin
         send_word(0, 8'h00); send_word(0, p); send_word(0, 8'h00);  // running status
      end else if (kind < 82) begin
         send_word(0, 8'h81); send_word(0, 8'h00);
         send_word(0, ST_META); send_word(0, 8'h01); send_word(0, 8'h02);
         send_word(0, 8'($urandom)); send_word(0, 8'($urandom));
      end else if (kind < 88) begin
         send_word(0, 8'h00); send_word(0, ST_SYSEX); send_word(0, 8'h01);
         send_word(0, 8'hF7);
      end else if (kind < 92) begin
         send_word(0, 8'h00); send_word(0, {KIND_PROG, chan}); send_word(0, 8'($urandom));
      end else if (kind < 98)
         send_word(0, 8'($urandom));
      else
         send_word(1, 8'h00);
   endtask

   initial begin
      notes = new();
      notes.set_channel(0);
      notes.clear_track();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      chan = 0;

      // directed: extremes, running status, close, no match, pitch out of range
      send_note(8'h90, 8'h00, 8'hFF);
      send_word(0, 8'hFF); send_word(0, 8'hFF); send_word(0, 8'hFF); send_word(0, 8'h7F);
      send_word(0, 8'h90); send_word(0, 8'h7F); send_word(0, 8'h01);
      send_word(0, 8'h00); send_word(0, 8'h7F); send_word(0, 8'h00);
      send_note(8'h80, 8'h00, 8'h40);
      send_note(8'h80, 8'h05, 8'h40);
      send_note(8'h90, 8'h80, 8'h40);
      send_note(8'h90, 8'h10, 8'h40);
      send_word(0, 8'h83);                 // partial delta then flush
      send_word(1, 8'h00);
      // end-of-track meta halts the parser
      send_note(8'h90, 8'h20, 8'h10);
      send_word(0, 8'h00); send_word(0, ST_META); send_word(0, META_EOT);
      send_word(0, 8'h00); send_note(8'h80, 8'h20, 8'h00);
      send_word(1, 8'h00);
      send_word(1, 8'h00);                 // empty flush
      send_word(0, 8'h00); send_word(0, 8'h40);  // data with no running status
      send_word(1, 8'h00);
      send_word(0, 8'h00); send_word(0, 8'hF3);  // illegal system status
      send_word(1, 8'h00);

      // pool overflow
      for (int i = 0; i < 18; i++) send_note(8'h90, 8'(i), 8'(i + 1));
      send_word(1, 8'h00);

      for (int ph = 0; ph < 4; ph++) begin
         chan = (ph == 0) ? 4'd15 : (ph == 1) ? 4'd0 : 4'($urandom);
         set_channel(chan);
         if (ph == 1) begin
            // first close starts the hold-off, the second one stalls the input
            long_hold = 1;
            for (int i = 0; i < 2; i++) begin
               send_note({KIND_ON, chan}, 8'h40, 8'h30);
               send_note({KIND_OFF, chan}, 8'h40, 8'h00);
            end
         end
         for (int i = 0; i < 6; i++) random_event();
         send_word(1, 8'h00);
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   // result side: random stalls, and one long hold-off while input keeps coming
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 0;
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
         end
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
               ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         notes.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         @(negedge clock);
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (stim_done && notes.expected_notes.size() == 0) begin
            repeat (300) @(posedge clock);
            if (notes.errors == 0 && notes.expected_notes.size() == 0 && !rsp_tvalid)
               $display("TEST PASSED");
            else begin
               if (rsp_tvalid) $error("extra result word after end");
               $display("TEST FAILED");
            end
            $finish;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end
endmodule
